// ----- design/assert_macros.svh -----
// Assertion helper macros shared by the RTL files.
// No dependencies; pulled in with an include by the modules that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ----- design/srank_pkg.sv -----
// Shared constants, types and helpers for the sliding window rank block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package srank_pkg;

   // Storage and field sizes
   localparam int WINDOW_MAX  = 64;
   localparam int SAMPLE_BITS = 32;
   localparam int LEN_BITS    = 7;
   localparam int RANK_BITS   = 6;
   localparam int LEN_RESET   = 64;

   // One cell per older sample the new one is compared against
   localparam int CELL_COUNT = WINDOW_MAX - 1;
   localparam int FILL_BITS  = $clog2(WINDOW_MAX + 1);
   localparam int SUM_BITS   = $clog2(WINDOW_MAX);

   // Popcount tree: groups of eight compare bits
   localparam int GROUP_SIZE     = 8;
   localparam int GROUPS         = (CELL_COUNT + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int PAD_BITS       = GROUPS * GROUP_SIZE;
   localparam int GROUP_CNT_BITS = $clog2(GROUP_SIZE + 1);

   // Per-cell control from the top level
   typedef struct packed {
      logic shift;   // item accepted: compare and move samples one cell on
      logic active;  // cell lies inside the current window and rank holds
   } cell_ctl_type;

   // Map the written length to the one in force: zero acts as one,
   // anything beyond the store depth acts as the depth.
   function automatic logic [FILL_BITS-1:0] clamp_len(input logic [LEN_BITS-1:0] len);
      logic [FILL_BITS+LEN_BITS-1:0] wide;
      wide = (FILL_BITS + LEN_BITS)'(len);
      if (len == '0) begin
         clamp_len = FILL_BITS'(1);
      end else if (wide > (FILL_BITS + LEN_BITS)'(WINDOW_MAX)) begin
         clamp_len = FILL_BITS'(WINDOW_MAX);
      end else begin
         clamp_len = wide[FILL_BITS-1:0];
      end
   endfunction

endpackage

// ----- design/srank_cell.sv -----
// One cell of the sample chain: holds one older sample and compares it
// against the incoming sample. Depends on srank_pkg.
`timescale 1ns / 1ps

module srank_cell
   import srank_pkg::*;
(
   input  logic                          clock,
   input  cell_ctl_type                  ctl,
   input  logic signed [SAMPLE_BITS-1:0] shift_in,
   input  logic signed [SAMPLE_BITS-1:0] probe,
   output logic signed [SAMPLE_BITS-1:0] shift_out,
   output logic                          less
);

   logic signed [SAMPLE_BITS-1:0] data_ff, data_in;
   logic                          less_ff, less_in;

   // Compare the held sample, then take the neighbor's
   always_comb begin
      data_in = shift_in;
      less_in = ctl.active && (data_ff < probe);
   end

   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         data_ff <= data_in;
         less_ff <= less_in;
      end
   end

   assign shift_out = data_ff;
   assign less      = less_ff;

endmodule

// ----- design/srank_count.sv -----
// Two-level popcount of the cell compare bits: registered group counts,
// then a sum over the groups. Depends on srank_pkg.
`timescale 1ns / 1ps

module srank_count
   import srank_pkg::*;
(
   input  logic                  clock,
   input  logic                  load,
   input  logic [CELL_COUNT-1:0] less,
   output logic [SUM_BITS-1:0]   total
);

   logic [PAD_BITS-1:0]       bits_pad;
   logic [GROUP_CNT_BITS-1:0] group_ff [GROUPS];
   logic [GROUP_CNT_BITS-1:0] group_in [GROUPS];

   assign bits_pad = PAD_BITS'(less);

   // Count each group of eight
   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         group_in[g] = '0;
         for (int b = 0; b < GROUP_SIZE; b++) begin
            group_in[g] = group_in[g] + GROUP_CNT_BITS'(bits_pad[g*GROUP_SIZE + b]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         group_ff <= group_in;
      end
   end

   // Sum the group counts
   always_comb begin
      total = '0;
      for (int g = 0; g < GROUPS; g++) begin
         total = total + SUM_BITS'(group_ff[g]);
      end
   end

endmodule

// ----- design/sliding_window_rank_top.sv -----
// Sliding window rank: top level with the cell chain, fill tracking,
// pipeline control and output register. Depends on srank_pkg,
// srank_cell, srank_count and assert_macros.svh.
// Usage:
//   req_ channel: one signed sample per item, plus req_last_sample that
//   closes a sequence. rsp_ channel: one result per item, rsp_rank is the
//   count of the older window samples strictly below the new one, and
//   rsp_rank_valid is 0 while the window is still filling.
//   csr_: window length, written with csr_wr_en while the block is idle.
// Timing:
//   An accepted item passes the compare stage, the group count stage and
//   the output register in turn before its result is on the rsp_ ports.
//   While rsp_ready is high, one item per cycle is taken and delivered; the
//   compare cells see every stored sample at once, nothing iterates per item.
// Reset:
//   Pipeline emptied, fill count cleared, window length back to 64.
//   Stored samples are not cleared; they are only read once refilled.
// Stall:
//   When rsp_ready stays low the three stages fill up and req_ready drops;
//   it rises in the same cycle rsp_ready returns high, as every stage moves.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sliding_window_rank_top
   import srank_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          req_last_sample,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [RANK_BITS-1:0]          rsp_rank,
   output logic                          rsp_rank_valid,
   // configuration
   input  logic                          csr_wr_en,
   input  logic [LEN_BITS-1:0]           csr_wr_data
);

   // Window length in force
   logic [FILL_BITS-1:0] len_ff, len_in;
   logic [FILL_BITS-1:0] fill_count_ff, fill_count_in;

   // Pipeline occupancy and rank-holds flags
   logic a_vld_ff, a_vld_in;
   logic b_vld_ff, b_vld_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic a_ok_ff, b_ok_ff;
   logic [RANK_BITS-1:0] rsp_rank_ff;
   logic                 rsp_rank_valid_ff;

   logic a_free, b_free, c_free;
   logic accept, b_load, c_load;
   logic window_full;

   logic signed [SAMPLE_BITS-1:0] chain [CELL_COUNT+1];
   logic [CELL_COUNT-1:0]         less;
   logic [SUM_BITS-1:0]           total;

   // Handshake and stage advance
   always_comb begin
      c_free = !rsp_valid_ff || rsp_ready;
      b_free = !b_vld_ff || c_free;
      a_free = !a_vld_ff || b_free;
      accept = req_valid && a_free;
      b_load = a_vld_ff && b_free;
      c_load = b_vld_ff && c_free;
   end

   assign req_ready = a_free;

   // Occupancy next state
   always_comb begin
      a_vld_in     = a_free ? accept   : a_vld_ff;
      b_vld_in     = b_free ? a_vld_ff : b_vld_ff;
      rsp_valid_in = c_free ? b_vld_ff : rsp_valid_ff;
   end

   // Fill tracking: saturating count, cleared after a last sample
   assign window_full = (fill_count_ff >= len_ff);

   always_comb begin
      fill_count_in = fill_count_ff;
      if (accept) begin
         if (req_last_sample) begin
            fill_count_in = '0;
         end else if (fill_count_ff < FILL_BITS'(WINDOW_MAX)) begin
            fill_count_in = fill_count_ff + FILL_BITS'(1);
         end
      end
   end

   // Configuration write
   always_comb begin
      len_in = csr_wr_en ? clamp_len(csr_wr_data) : len_ff;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff      <= 1'b0;
         b_vld_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         fill_count_ff <= '0;
         len_ff        <= clamp_len(LEN_BITS'(LEN_RESET));
      end else begin
         a_vld_ff      <= a_vld_in;
         b_vld_ff      <= b_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
         fill_count_ff <= fill_count_in;
         len_ff        <= len_in;
      end
   end

   // Payload registers along the pipeline
   always_ff @(posedge clock) begin
      if (accept) begin
         a_ok_ff <= window_full;
      end
      if (b_load) begin
         b_ok_ff <= a_ok_ff;
      end
      if (c_load) begin
         rsp_rank_ff       <= RANK_BITS'(total);
         rsp_rank_valid_ff <= b_ok_ff;
      end
   end

   // Cell chain: cell k holds the sample from k+1 items back
   assign chain[0] = req_sample;

   for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
      cell_ctl_type ctl;

      assign ctl.shift  = accept;
      assign ctl.active = window_full && (len_ff > FILL_BITS'(i + 1));

      srank_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .shift_in  (chain[i]),
         .probe     (req_sample),
         .shift_out (chain[i+1]),
         .less      (less[i])
      );
   end

   // Popcount of the compare bits
   srank_count u_count (
      .clock (clock),
      .load  (b_load),
      .less  (less),
      .total (total)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_rank       = rsp_rank_ff;
   assign rsp_rank_valid = rsp_rank_valid_ff;

   // Checks
   `ASSERT_IMPLIES(a_fill_bound, clock, reset, 1'b1,
      fill_count_ff <= FILL_BITS'(WINDOW_MAX))
   `ASSERT_NEXT(a_last_clears, clock, reset, accept && req_last_sample,
      fill_count_ff == '0)
   `ASSERT_IMPLIES(a_filling_zero, clock, reset, rsp_valid_ff && !rsp_rank_valid_ff,
      rsp_rank_ff == '0)
   `ASSERT_IMPLIES(a_stall_full, clock, reset, !req_ready,
      a_vld_ff && b_vld_ff && rsp_valid_ff && !rsp_ready)

endmodule
